>>> sv/iptw_pkg.sv
`default_nettype none
package iptw_pkg;

  localparam int unsigned STORE_WORDS_DEF = 4096;

  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned IOVA_W    = 36;
  localparam int unsigned LVL_IDX_W = 8;

  localparam int unsigned LVL0_SHIFT = 28;
  localparam int unsigned LVL1_SHIFT = 20;
  localparam int unsigned LVL2_SHIFT = 12;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_WALK  = 1'b1;

  localparam logic [1:0] LVL0 = 2'd0;
  localparam logic [1:0] LVL1 = 2'd1;
  localparam logic [1:0] LVL2 = 2'd2;

  localparam logic [ENTRY_W-1:0] FAULT_ADDR = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_READ = 3'b100
  } walk_state_t;

endpackage
`default_nettype wire

>>> sv/iptw_ram.sv
`default_nettype none
module iptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> sv/iommu_page_table_walker.sv
`default_nettype none
// IOMMU three-level translation-table walker with a private entry store.
// Input transaction: accepted on a rising edge with start high and busy low.
//   in_opcode 0 writes in_entry_value to store word in_entry_index (ignored
//   when the index lies beyond the store); 1 walks in_io_address from the
//   level-0 table at in_table_base.
// Result: out_valid pulses for one cycle with out_phys_address/out_fault;
//   there is no backpressure, the receiver must take it in that cycle.
// Timing: a write returns its result in the cycle after acceptance and the
//   block can take the next transaction in that same cycle. For each level a
//   walk takes the word address + range check, then the registered store
//   read; a word outside the store faults after the address state alone.
//   Busy stays high until the strobe cycle, in which the next transaction
//   can be accepted. The single store port and the dependent entry reads
//   make a walk read its levels one after another.
// Configuration: cfg_write_en/cfg_write_data load memory_base; write only
//   while busy is low and no result is pending.
// Reset (synchronous, rst_n low): returns to idle, clears memory_base and
//   the strobe. The store is not cleared; walks must touch written words only.
module iommu_page_table_walker #(
  parameter int unsigned STORE_WORDS = iptw_pkg::STORE_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_opcode,
  input  wire logic [iptw_pkg::INDEX_W-1:0]   in_entry_index,
  input  wire logic [iptw_pkg::ENTRY_W-1:0]   in_entry_value,
  input  wire logic [iptw_pkg::ENTRY_W-1:0]   in_table_base,
  input  wire logic [iptw_pkg::IOVA_W-1:0]    in_io_address,
  input  wire logic                           cfg_write_en,
  input  wire logic [iptw_pkg::ENTRY_W-1:0]   cfg_write_data,
  output logic                                out_valid,
  output logic      [iptw_pkg::ENTRY_W-1:0]   out_phys_address,
  output logic                                out_fault
);
  import iptw_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam int unsigned DW = ENTRY_W - 3;
  localparam int unsigned SW = DW + 1;
  localparam logic [31:0] DEPTH32 = 32'(STORE_WORDS);

  walk_state_t           state_r, state_nxt;
  logic [1:0]            level_r, level_nxt;
  logic [DW-1:0]         diff_r, diff_nxt;
  logic [IOVA_W-1:0]     va_r, va_nxt;
  logic [ENTRY_W-1:0]    base_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0]    out_pa_r, out_pa_nxt;
  logic                  out_fault_r, out_fault_nxt;

  logic                  accept;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  logic [LVL_IDX_W-1:0]  idx_sel;
  logic [SW-1:0]         word_sum;
  logic                  in_store;
  logic [ENTRY_W-1:0]    next_tbl;
  logic [ENTRY_W-1:0]    sub_a;
  logic [ENTRY_W-1:0]    diff64;

  assign accept  = start && !busy;
  assign wr_en   = accept && (in_opcode == OP_WRITE) &&
                   ({20'd0, in_entry_index} < DEPTH32);
  assign wr_addr = AW'({20'd0, in_entry_index});

  always_comb begin
    unique case (level_r)
      LVL0:    idx_sel = va_r[LVL0_SHIFT +: LVL_IDX_W];
      LVL1:    idx_sel = va_r[LVL1_SHIFT +: LVL_IDX_W];
      default: idx_sel = va_r[LVL2_SHIFT +: LVL_IDX_W];
    endcase
  end

  assign word_sum = {1'b0, diff_r} + SW'(idx_sel);
  assign in_store = word_sum < SW'(STORE_WORDS);
  assign rd_en    = (state_r == ST_ADDR) && in_store;
  assign rd_addr  = word_sum[AW-1:0];

  // one subtractor serves the level-0 base at accept and each next table
  assign next_tbl = {rd_data[ENTRY_W-1:LVL2_SHIFT], {LVL2_SHIFT{1'b0}}};
  assign sub_a    = (state_r == ST_READ) ? next_tbl : in_table_base;
  assign diff64   = sub_a - base_r;

  iptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    diff_nxt      = diff_r;
    va_nxt        = va_r;
    out_valid_nxt = 1'b0;
    out_pa_nxt    = out_pa_r;
    out_fault_nxt = out_fault_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_WRITE) begin
            out_valid_nxt = 1'b1;
            out_pa_nxt    = '0;
            out_fault_nxt = 1'b0;
          end else begin
            va_nxt    = in_io_address;
            diff_nxt  = diff64[ENTRY_W-1:3];
            level_nxt = LVL0;
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        if (in_store) begin
          state_nxt = ST_READ;
        end else begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = FAULT_ADDR;
          out_fault_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        priority if (!rd_data[0]) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = FAULT_ADDR;
          out_fault_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (level_r == LVL0 && rd_data[1]) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = {rd_data[ENTRY_W-1:LVL0_SHIFT], va_r[LVL0_SHIFT-1:0]};
          out_fault_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (level_r == LVL1 && rd_data[1]) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = {rd_data[ENTRY_W-1:LVL1_SHIFT], va_r[LVL1_SHIFT-1:0]};
          out_fault_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (level_r == LVL2) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = {rd_data[ENTRY_W-1:LVL2_SHIFT], va_r[LVL2_SHIFT-1:0]};
          out_fault_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          diff_nxt  = diff64[ENTRY_W-1:3];
          level_nxt = level_r + 2'd1;
          state_nxt = ST_ADDR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        base_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r     <= level_nxt;
    diff_r      <= diff_nxt;
    va_r        <= va_nxt;
    out_pa_r    <= out_pa_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_phys_address = out_pa_r;
  assign out_fault        = out_fault_r;

endmodule
`default_nettype wire

>>> sv/iptw_checker.sv
`default_nettype none
module iptw_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         in_opcode,
  input wire logic                         out_valid,
  input wire logic                         out_fault,
  input wire logic [iptw_pkg::ENTRY_W-1:0] out_phys_address
);
  import iptw_pkg::*;

  // a result strobe always leaves the walker ready for the next transaction
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy high while a result is shown");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_WRITE) |=>
      (out_valid && !out_fault && out_phys_address == '0))
    else $error("write transaction did not return its result next cycle");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_WALK) |=> (busy && !out_valid))
    else $error("walk transaction did not hold busy");

  a_fault_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (out_phys_address == FAULT_ADDR))
    else $error("fault result without all-ones address");

endmodule

bind iommu_page_table_walker iptw_checker u_iptw_checker (.*);
`default_nettype wire

>>> bench/iommu_page_table_walker_tb.sv
module iommu_page_table_walker_tb;
  import iptw_pkg::*;

  localparam int unsigned WORDS = STORE_WORDS_DEF;

  typedef struct {
    logic                  op;
    logic [INDEX_W-1:0]    idx;
    logic [ENTRY_W-1:0]    val;
    logic [ENTRY_W-1:0]    tb;
    logic [IOVA_W-1:0]     va;
  } walk_req_t;

  typedef struct {
    logic [ENTRY_W-1:0] pa;
    logic               fault;
  } xlate_t;

  typedef struct {
    logic [ENTRY_W-1:0] tb;
    logic [IOVA_W-1:0]  va;
  } walk_ref_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_opcode;
  logic [INDEX_W-1:0]   in_entry_index;
  logic [ENTRY_W-1:0]   in_entry_value;
  logic [ENTRY_W-1:0]   in_table_base;
  logic [IOVA_W-1:0]    in_io_address;
  logic                 cfg_write_en;
  logic [ENTRY_W-1:0]   cfg_write_data;
  logic                 out_valid;
  logic [ENTRY_W-1:0]   out_phys_address;
  logic                 out_fault;

  // shadow of the entry store and the base register
  logic [ENTRY_W-1:0]   pt_store [WORDS];
  bit                   pt_written [WORDS];
  logic [ENTRY_W-1:0]   pt_base = '0;

  xlate_t               translation_q [$];
  walk_ref_t            recent [$];
  bit                   no_idle;
  int unsigned          n_items, n_writes, n_walks, n_faults, n_bases, n_errors;

  iommu_page_table_walker u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_table_base    (in_table_base),
    .in_io_address    (in_io_address),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .out_valid        (out_valid),
    .out_phys_address (out_phys_address),
    .out_fault        (out_fault)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // blank is set when the walk would read a store word never written
  function automatic void translate_iova(input logic [ENTRY_W-1:0] tb,
                                         input logic [IOVA_W-1:0] va,
                                         output xlate_t res, output bit blank);
    logic [ENTRY_W-1:0] tbl, word, entry, keep;
    int unsigned shift;
    tbl = tb;
    blank = 1'b0;
    res.pa = FAULT_ADDR;
    res.fault = 1'b1;
    for (int lvl = 0; lvl < 3; lvl++) begin
      shift = LVL0_SHIFT - LVL_IDX_W * lvl;
      word = ((tbl - pt_base) >> 3) + 64'(va[shift +: LVL_IDX_W]);
      if (word >= WORDS) return;
      if (!pt_written[word[INDEX_W-1:0]]) begin
        blank = 1'b1;
        return;
      end
      entry = pt_store[word[INDEX_W-1:0]];
      if (!entry[0]) return;
      if (lvl == 2 || entry[1]) begin
        keep = (64'd1 << shift) - 64'd1;
        res.pa = (entry & ~keep) | (64'(va) & keep);
        res.fault = 1'b0;
        return;
      end
      tbl = entry & ~64'hFFF;
    end
  endfunction

  function automatic walk_req_t make_write(input logic [INDEX_W-1:0] idx,
                                           input logic [ENTRY_W-1:0] val);
    walk_req_t r;
    r.op  = OP_WRITE;
    r.idx = idx;
    r.val = val;
    r.tb  = {$urandom, $urandom};
    r.va  = IOVA_W'({$urandom, $urandom});
    return r;
  endfunction

  function automatic walk_req_t make_walk(input logic [ENTRY_W-1:0] tb,
                                          input logic [IOVA_W-1:0] va);
    walk_req_t r;
    r.op  = OP_WALK;
    r.idx = INDEX_W'($urandom);
    r.val = {$urandom, $urandom};
    r.tb  = tb;
    r.va  = va;
    return r;
  endfunction

  task automatic send_item(input walk_req_t req);
    xlate_t      res;
    bit          blank;
    int unsigned gap, p;
    gap = 0;
    if (!no_idle) begin
      p = $urandom_range(0, 99);
      if (p >= 88) gap = $urandom_range(6, 30);
      else if (p >= 45) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // a walk into unwritten words is turned into a base-underflow fault
    if (req.op == OP_WALK) begin
      translate_iova(req.tb, req.va, res, blank);
      if (blank) req.tb = pt_base - 64'd8;
    end
    start          <= 1'b1;
    in_opcode      <= req.op;
    in_entry_index <= req.idx;
    in_entry_value <= req.val;
    in_table_base  <= req.tb;
    in_io_address  <= req.va;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (req.op == OP_WRITE) begin
      if (32'(req.idx) < WORDS) begin
        pt_store[req.idx]   = req.val;
        pt_written[req.idx] = 1'b1;
      end
      res.pa    = '0;
      res.fault = 1'b0;
      n_writes++;
    end else begin
      translate_iova(req.tb, req.va, res, blank);
      n_walks++;
      if (res.fault) n_faults++;
    end
    translation_q.push_back(res);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (translation_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_memory_base(input logic [ENTRY_W-1:0] base);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= base;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pt_base = base;
    n_bases++;
  endtask

  // lays down a table chain for a random address, then walks it
  task automatic build_walk();
    logic [IOVA_W-1:0]  va;
    logic [ENTRY_W-1:0] tb, tbl, e, word;
    int unsigned        shift, pick, k;
    bit                 stop;
    va = IOVA_W'({$urandom, $urandom});
    stop = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      tb = pt_base - 64'(8 * $urandom_range(1, 64));
      stop = 1'b1;
    end else begin
      tb = pt_base + 64'(8 * $urandom_range(0, WORDS - 256)) + 64'($urandom_range(0, 7));
    end
    tbl = tb;
    for (int lvl = 0; lvl < 3 && !stop; lvl++) begin
      shift = LVL0_SHIFT - LVL_IDX_W * lvl;
      word = ((tbl - pt_base) >> 3) + 64'(va[shift +: LVL_IDX_W]);
      if (word >= WORDS) begin
        stop = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        e = {$urandom, $urandom};
        stop = 1'b1;
        if (pick < 8) begin
          e[0] = 1'b0;
        end else if (lvl == 2) begin
          e[0] = 1'b1;
        end else if (pick < 33) begin
          e[1:0] = 2'b11;
        end else begin
          k = (pick < 38) ? $urandom_range(8, 1 << 20) : $urandom_range(0, 6);
          tbl = ((pt_base + 64'hFFF) & ~64'hFFF) + (64'(k) << 12);
          e = {tbl[63:12], e[11:2], 2'b01};
          stop = 1'b0;
        end
        send_item(make_write(word[INDEX_W-1:0], e));
      end
    end
    send_item(make_walk(tb, va));
    recent.push_back('{tb: tb, va: va});
    if (recent.size() > 32) void'(recent.pop_front());
  endtask

  task automatic run_mixed(input int unsigned n, input int unsigned noise_pct);
    int unsigned       stop_at, pick;
    walk_ref_t         old;
    logic [IOVA_W-1:0] mask;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        case ($urandom_range(0, 3))
          0, 1: send_item(make_write(INDEX_W'($urandom), {$urandom, $urandom}));
          2: send_item(make_walk({$urandom, $urandom}, IOVA_W'({$urandom, $urandom})));
          default: begin
            send_item(make_walk(pt_base + 64'(8 * $urandom_range(0, WORDS - 1))
                                + 64'($urandom_range(0, 7)),
                                IOVA_W'({$urandom, $urandom})));
          end
        endcase
      end else if (pick < noise_pct + 15 && recent.size() != 0) begin
        old = recent[$urandom_range(0, recent.size() - 1)];
        case ($urandom_range(0, 2))
          0: mask = 36'hFFF;
          1: mask = 36'hF_FFFF;
          default: mask = 36'hFFF_FFFF;
        endcase
        send_item(make_walk(old.tb, old.va ^ (IOVA_W'($urandom) & mask)));
      end else begin
        build_walk();
      end
    end
  endtask

  // base is zero from reset here
  task automatic test_directed_cases();
    send_item(make_write(12'd0, '1));
    send_item(make_walk(64'd0, 36'h0_0FFF_FFFF));
    send_item(make_write(12'd4095, 64'd0));
    send_item(make_walk(64'h7800, 36'hF_F000_0000));
    send_item(make_write(12'd1, 64'h1001));
    send_item(make_write(12'd515, 64'hABCD_0000_0000_0003));
    send_item(make_walk(64'd0, {8'd1, 8'd3, 20'hABCDE}));
    send_item(make_write(12'd2, 64'h2001));
    send_item(make_write(12'd1028, 64'h3001));
    send_item(make_write(12'd1541, 64'h8000_0000_1234_5001));
    send_item(make_write(12'd1542, 64'h7FFF_FFFF_FFFF_F003));
    send_item(make_walk(64'd0, {8'd2, 8'd4, 8'd5, 12'hABC}));
    send_item(make_walk(64'd0, {8'd2, 8'd4, 8'd6, 12'h123}));
    send_item(make_write(12'd1029, 64'd0));
    send_item(make_walk(64'd0, {8'd2, 8'd5, 8'd9, 12'h000}));
    send_item(make_write(12'd1543, 64'hFFFF_FFFF_FFFF_FFFE));
    send_item(make_walk(64'd0, {8'd2, 8'd4, 8'd7, 12'hFFF}));
    send_item(make_write(12'd3, 64'h8001));
    send_item(make_walk(64'd0, {8'd3, 8'd0, 8'd0, 12'h000}));
    send_item(make_write(12'd1030, 64'hFFFF_FFFF_FFFF_F001));
    send_item(make_walk(64'd0, {8'd2, 8'd6, 8'd1, 12'h001}));
    send_item(make_walk(64'hFFFF_FFFF_FFFF_FFF8, 36'h0));
    send_item(make_write(12'd255, 64'h1234_5678_9000_0003));
    send_item(make_walk(64'd0, 36'hF_FFFF_FFFF));
    send_item(make_walk(64'd0, 36'h0));
  endtask

  task automatic test_base_extremes();
    set_memory_base('1);
    run_mixed(210, 20);
    set_memory_base('0);
    run_mixed(210, 20);
  endtask

  task automatic test_random_bases();
    set_memory_base({$urandom, $urandom} & ~64'hFFF);
    run_mixed(190, 20);
    set_memory_base({$urandom, $urandom});
    run_mixed(190, 20);
    set_memory_base(64'd0 - 64'(8 * $urandom_range(1, 4000)));
    run_mixed(190, 20);
  endtask

  task automatic test_noise();
    set_memory_base({$urandom, $urandom});
    run_mixed(135, 80);
  endtask

  always @(posedge clk) begin : check_results
    xlate_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (translation_q.size() == 0) begin
        $error("unexpected transaction: phys_address %h fault %b",
               out_phys_address, out_fault);
        n_errors++;
      end else begin
        want = translation_q.pop_front();
        if (out_phys_address !== want.pa) begin
          $error("phys_address: expected %h, got %h", want.pa, out_phys_address);
          n_errors++;
        end
        if (out_fault !== want.fault) begin
          $error("fault: expected %b, got %b", want.fault, out_fault);
          n_errors++;
        end
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_WRITE;
    in_entry_index <= '0;
    in_entry_value <= '0;
    in_table_base  <= '0;
    in_io_address  <= '0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_base_extremes();
    test_random_bases();
    test_noise();

    wait_idle();
    $display("Covered %0d entry writes and %0d walks (%0d faulting) over %0d base settings,",
             n_writes, n_walks, n_faults, n_bases + 1);
    $display("including zero, all ones and a base that wraps past the top of the space.");
    if (n_errors == 0 && translation_q.size() == 0) begin
      $display("** iommu_page_table_walker: PASSED **");
    end else begin
      $display("** iommu_page_table_walker: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("** iommu_page_table_walker: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
sv/iptw_pkg.sv
sv/iptw_ram.sv
sv/iommu_page_table_walker.sv
sv/iptw_checker.sv
bench/iommu_page_table_walker_tb.sv
